[design/msd_pkg.sv]
// msd_pkg: shared widths, defaults and controller/datapath command and status types
// for the mean and standard deviation block; no dependencies
package msd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int STD_W       = 15;
	localparam int COUNT_W     = 11;
	localparam int MAX_SAMPLES = 1024;
	localparam int ROOT_IN_W   = 2 * SAMPLE_W;
	localparam int ROOT_W      = SAMPLE_W;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic take;       // store and sum the accepted sample
		logic div_mean;   // start dividing the sum by the count
		logic mean_load;  // capture the signed quotient as the mean
		logic pass_start; // rewind the read address, clear the square sum
		logic pass_rd;    // read one stored sample for the deviation pass
		logic div_var;    // start dividing the square sum by the count
		logic sqrt_start; // start the root of the variance
		logic out_load;   // load the result register, clear the run
	} cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic rd_last;
		logic pipe_busy;
		logic out_blocked;
	} sts_t;

endpackage

[design/msd_if.sv]
// msd_if: valid/ready channels for the sample stream and the result stream
// depends on msd_pkg
interface msd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [msd_pkg::SAMPLE_W-1:0] sample;
	logic                                last;

	modport source(output valid, sample, last, input ready);
	modport sink(input valid, sample, last, output ready);
endinterface

interface msd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [msd_pkg::SAMPLE_W-1:0] mean;
	logic        [msd_pkg::STD_W-1:0]    std_dev;
	logic        [msd_pkg::COUNT_W-1:0]  count;
	logic                                overflowed;

	modport source(output valid, mean, std_dev, count, overflowed, input ready);
	modport sink(input valid, mean, std_dev, count, overflowed, output ready);
endinterface

[design/msd_ram.sv]
// msd_ram: generic single write port, single read port ram with registered read
// no dependencies
module msd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/msd_div.sv]
// msd_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies
module msd_div #(
	parameter int NUM_W = 43,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, acc_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = acc_q;

endmodule

[design/msd_sqrt.sv]
// msd_sqrt: digit by digit integer square root, one root bit per cycle
// depends on msd_pkg for the operand widths
module msd_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [msd_pkg::ROOT_IN_W-1:0]  val,
	output logic                           done,
	output logic [msd_pkg::ROOT_W-1:0]     root
);

	localparam int IW    = msd_pkg::ROOT_IN_W;
	localparam int RTW   = msd_pkg::ROOT_W;
	localparam int RW    = RTW + 2;
	localparam int CNT_W = $clog2(RTW + 1);

	logic [IW-1:0]    val_q;
	logic [RW-1:0]    rem_q;
	logic [RTW-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [RW-1:0]    rem_sh;
	logic [RW-1:0]    trial;
	logic             ge;

	assign rem_sh = {rem_q[RW-3:0], val_q[IW-1:IW-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(RTW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			val_q  <= {val_q[IW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RTW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[design/msd_dp.sv]
// msd_dp: sample store, running sum, deviation pass, shared divider, root unit
// and result register; depends on msd_pkg, msd_ram, msd_div, msd_sqrt
module msd_dp #(
	parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msd_pkg::cmd_t                       cmd,
	output msd_pkg::sts_t                       sts,
	input  logic        [msd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [msd_pkg::SAMPLE_W-1:0] mean,
	output logic        [msd_pkg::STD_W-1:0]    std_dev,
	output logic        [msd_pkg::COUNT_W-1:0]  count,
	output logic                                overflowed
);

	localparam int DW  = msd_pkg::SAMPLE_W;
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int SW  = DW + CW;
	localparam int QW  = 2 * DW + CW;
	localparam int OCW = msd_pkg::COUNT_W;

	// run state
	logic [SW-1:0]  sum_q;
	logic [CW-1:0]  count_q;
	logic           drop_q;
	logic [DW-1:0]  mean_q;
	logic [CW-1:0]  rd_addr_q;
	logic [QW-1:0]  sumsq_q;
	logic           room;
	logic [CW-1:0]  rd_next;
	logic [SW-1:0]  sum_mag;
	logic [DW-1:0]  quo_lo;

	// deviation pipeline
	logic                v_s1, v_s2, v_s3;
	logic [DW-1:0]       rdata;
	logic signed [DW:0]  dev_s2;
	logic signed [2*DW+1:0] sq_full;
	logic [2*DW-1:0]     sq_s3;

	// shared units
	logic [QW-1:0]                        div_num;
	logic [QW-1:0]                        div_quo;
	logic                                 div_done;
	logic                                 sqrt_done;
	logic [msd_pkg::ROOT_W-1:0]           root;

	// result register
	logic                valid_q;
	logic [DW-1:0]       mean_o_q;
	logic [msd_pkg::STD_W-1:0] std_o_q;
	logic [OCW-1:0]      cnt_o_q;
	logic                ovf_o_q;
	logic [CW+OCW-1:0]   cnt_ext;

	assign room    = count_q < CW'(MAX_SAMPLES);
	assign rd_next = rd_addr_q + 1'b1;
	assign sum_mag = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;
	assign quo_lo  = div_quo[DW-1:0];
	assign div_num = cmd.div_var ? sumsq_q : {{(QW - SW){1'b0}}, sum_mag};
	assign sq_full = dev_s2 * dev_s2;
	assign cnt_ext = {{OCW{1'b0}}, count_q};

	msd_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (cmd.take && room),
		.waddr(count_q[AW-1:0]),
		.wdata(sample),
		.re   (cmd.pass_rd),
		.raddr(rd_addr_q[AW-1:0]),
		.rdata(rdata)
	);

	msd_div #(
		.NUM_W(QW),
		.DEN_W(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_mean || cmd.div_var),
		.num   (div_num),
		.den   (count_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	msd_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.sqrt_start),
		.val   (div_quo[msd_pkg::ROOT_IN_W-1:0]),
		.done  (sqrt_done),
		.root  (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.pass_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.take) begin
				if (room) begin
					sum_q   <= sum_q + {{CW{sample[DW-1]}}, sample};
					count_q <= count_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				sum_q   <= '0;
				count_q <= '0;
				drop_q  <= 1'b0;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_load) begin
			mean_q <= sum_q[SW-1] ? (~quo_lo + DW'(1)) : quo_lo;
		end
		if (cmd.pass_start) begin
			rd_addr_q <= '0;
			sumsq_q   <= '0;
		end else begin
			if (cmd.pass_rd) begin
				rd_addr_q <= rd_next;
			end
			if (v_s3) begin
				sumsq_q <= sumsq_q + {{CW{1'b0}}, sq_s3};
			end
		end
		// deviation from the mean, then its square
		dev_s2 <= $signed({rdata[DW-1], rdata}) - $signed({mean_q[DW-1], mean_q});
		sq_s3  <= sq_full[2*DW-1:0];
		if (cmd.out_load) begin
			mean_o_q <= mean_q;
			std_o_q  <= root[msd_pkg::ROOT_W-1] ? {msd_pkg::STD_W{1'b1}}
				: root[msd_pkg::STD_W-1:0];
			cnt_o_q  <= cnt_ext[OCW-1:0];
			ovf_o_q  <= drop_q;
		end
	end

	always_comb begin
		sts             = '0;
		sts.div_done    = div_done;
		sts.sqrt_done   = sqrt_done;
		sts.rd_last     = (rd_next == count_q);
		sts.pipe_busy   = v_s1 || v_s2 || v_s3;
		sts.out_blocked = valid_q && !out_ready;
	end

	assign out_valid  = valid_q;
	assign mean       = mean_o_q;
	assign std_dev    = std_o_q;
	assign count      = cnt_o_q;
	assign overflowed = ovf_o_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(valid_q && !out_ready))
		else $error("result register overwritten while held");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_rd |-> rd_addr_q < count_q)
		else $error("deviation pass reads beyond stored samples");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (count_q == '0) && !drop_q && valid_q)
		else $error("run state not cleared after result");

endmodule

[design/msd_ctrl.sv]
// msd_ctrl: sequencer for load, mean division, deviation pass, variance
// division, root and result hand-off; depends on msd_pkg
module msd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output msd_pkg::cmd_t cmd,
	input  msd_pkg::sts_t sts
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DMEAN = 3'd2;
	localparam logic [2:0] S_PASS  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DVAR  = 3'd5;
	localparam logic [2:0] S_ROOT  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.div_mean = 1'b1;
				state_d      = S_DMEAN;
			end
			S_DMEAN: begin
				if (sts.div_done) begin
					cmd.mean_load  = 1'b1;
					cmd.pass_start = 1'b1;
					state_d        = S_PASS;
				end
			end
			S_PASS: begin
				cmd.pass_rd = 1'b1;
				if (sts.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.div_var = 1'b1;
					state_d     = S_DVAR;
				end
			end
			S_DVAR: begin
				if (sts.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_d        = S_ROOT;
				end
			end
			S_ROOT: begin
				if (sts.sqrt_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d      = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	a_last_leaves_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready && (state_q == S_START))
		else $error("last item did not start the final pass");

	a_pass_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pass_rd && sts.rd_last) |=> !cmd.pass_rd)
		else $error("deviation pass read past its last sample");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.take, cmd.div_mean, cmd.div_var, cmd.sqrt_start, cmd.out_load}) <= 1)
		else $error("overlapping datapath commands");

endmodule

[design/mean_and_std_deviation.sv]
// mean_and_std_deviation: top level, population mean and standard deviation
// of a run of signed q8.8 samples; depends on msd_pkg, msd_if, msd_ctrl, msd_dp
//
//   channel   dir   payload                              item
//   samples   in    sample[15:0] signed, last            one q8.8 reading
//   results   out   mean[15:0] signed, std_dev[14:0],    one per run, on the
//                   count[10:0], overflowed              item marked last
//
// samples are taken one per cycle while loading; a sample beyond capacity is
// dropped and flagged in the result
// after the last item the block takes no items until the run's result is loaded
// into the result register, which takes two passes of the shared bit-serial
// divider, one store read per sample and 16 root steps
// arst_n clears the sequencer, the run state and the result valid; the store
// needs no clearing, only entries below the count are read
// a stalled result sits in its register; the next run loads while it waits
// and only its own result hand-off waits for the register to free
module mean_and_std_deviation #(
	parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES
) (
	input  logic      clk,
	input  logic      arst_n,
	msd_in_if.sink    samples,
	msd_out_if.source results
);

	// command and status between sequencer and datapath
	msd_pkg::cmd_t cmd;
	msd_pkg::sts_t sts;

	// sequencer: owns the input handshake and the step order
	msd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_last (samples.last),
		.in_ready(samples.ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// datapath: store, sums, divider, root and the result register
	msd_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (samples.sample),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.mean      (results.mean),
		.std_dev   (results.std_dev),
		.count     (results.count),
		.overflowed(results.overflowed)
	);

endmodule

[bench/tb.sv]
// tb: self-checking bench for mean_and_std_deviation, feeding runs of q8.8 samples
// and checking each run's mean, std_dev, count and drop flag against its own model
// depends on msd_pkg, msd_if and the design files under design/
`timescale 1ns / 1ps

module tb;
	localparam int SAMPLE_W     = msd_pkg::SAMPLE_W;
	localparam int STD_W        = msd_pkg::STD_W;
	localparam int COUNT_W      = msd_pkg::COUNT_W;
	localparam int MAX_SAMPLES  = msd_pkg::MAX_SAMPLES;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int RANDOM_ITEMS = 1400;
	// worst case busy time after a last item, with margin
	localparam int DRAIN_CYCLES = MAX_SAMPLES + 2 * (32 + $clog2(MAX_SAMPLES + 1)) + 100;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} feed_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean;
		logic        [STD_W-1:0]    std_dev;
		logic        [COUNT_W-1:0]  count;
		logic                       overflowed;
	} run_stats_t;

	// how the samples of one random run are spread
	typedef enum int {
		SPREAD_FULL,
		SPREAD_NARROW,
		SPREAD_EXTREME,
		SPREAD_FLAT
	} spread_t;

	logic clk;
	logic arst_n;

	msd_in_if  samples_if ();
	msd_out_if results_if ();

	mean_and_std_deviation #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.results(results_if)
	);

	// ------------------------------------------------------------------
	// own model of the running statistics
	// ------------------------------------------------------------------

	logic signed [SAMPLE_W-1:0] held_samples [MAX_SAMPLES];
	longint                     run_sum;
	int                         run_len;
	bit                         run_dropped;

	// results still owed by the block, oldest first
	run_stats_t stats_due[$];
	// samples waiting to be offered, oldest first
	feed_item_t sample_feed[$];

	int errors;
	int runs_checked;
	int runs_dropped;
	int n_accepted;
	int hold_point;
	int burst_left;
	int gap_left;
	int stall_left;
	int cycles;

	// integer square root, floor, built up one bit at a time
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// fold one accepted sample into the run; a last item closes the run
	task automatic absorb_sample(feed_item_t smp);
		longint          mean_q;
		longint          dev;
		longint unsigned sq_sum;
		longint unsigned root;
		run_stats_t      st;
		if (run_len < MAX_SAMPLES) begin
			held_samples[run_len] = smp.sample;
			run_sum += longint'(smp.sample);
			run_len++;
		end else begin
			// store full: sample is lost, flag it for this run
			run_dropped = 1'b1;
		end
		if (smp.last) begin
			mean_q = 0;
			root   = 0;
			if (run_len != 0) begin
				// signed division truncates toward zero
				mean_q = run_sum / longint'(run_len);
				sq_sum = 0;
				for (int i = 0; i < run_len; i++) begin
					dev = longint'(held_samples[i]) - mean_q;
					sq_sum += longint'(dev * dev);
				end
				root = floor_root(sq_sum / longint'(run_len));
				if (root > 32767)
					root = 32767;
			end
			st.mean       = mean_q[SAMPLE_W-1:0];
			st.std_dev    = root[STD_W-1:0];
			st.count      = run_len[COUNT_W-1:0];
			st.overflowed = run_dropped;
			stats_due     = {stats_due, st};
			run_sum     = 0;
			run_len     = 0;
			run_dropped = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_sample(int v, bit is_last);
		feed_item_t smp;
		smp.sample  = v[SAMPLE_W-1:0];
		smp.last    = is_last;
		sample_feed = {sample_feed, smp};
	endtask

	function automatic int pick_sample(spread_t how, int centre, int spread);
		int v;
		case (how)
			SPREAD_FULL: begin
				v = int'($urandom_range(0, 65535)) - 32768;
			end
			SPREAD_NARROW: begin
				v = centre + int'($urandom_range(0, 2 * spread)) - spread;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
			SPREAD_EXTREME: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = -32768 + int'($urandom_range(0, 3));
					default: v = 32767 - int'($urandom_range(0, 3));
				endcase
			end
			default: begin
				v = centre;
			end
		endcase
		return v;
	endfunction

	// one well-formed run with random content, closed by a last item
	task automatic add_run(int len);
		spread_t how;
		int      centre;
		int      spread;
		how    = spread_t'($urandom_range(0, 3));
		centre = int'($urandom_range(0, 65535)) - 32768;
		spread = 1 << $urandom_range(0, 10);
		for (int i = 0; i < len; i++)
			push_sample(pick_sample(how, centre, spread), i == len - 1);
	endtask

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sample driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid  <= 1'b0;
			samples_if.sample <= '0;
			samples_if.last   <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				absorb_sample(sample_feed.pop_front());
				n_accepted++;
				if (burst_left > 0)
					burst_left--;
			end
			// an item on offer stays put until taken
			if (!(samples_if.valid && !samples_if.ready)) begin
				if (sample_feed.size() == 0 ||
						(n_accepted == hold_point && stats_due.size() != 0)) begin
					// nothing left, or holding off until the block has caught up
					samples_if.valid <= 1'b0;
				end else begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						// a quarter of the bursts follow on with no gap at all
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
					if (gap_left > 0) begin
						gap_left--;
						samples_if.valid <= 1'b0;
					end else begin
						samples_if.valid  <= 1'b1;
						samples_if.sample <= sample_feed[0].sample;
						samples_if.last   <= sample_feed[0].last;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: checks each result, stalls on a pattern of its own
	// ------------------------------------------------------------------

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_stats_t want;
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				if (stats_due.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected none actual mean %0d",
						$time, results_if.mean);
				end else begin
					want = stats_due.pop_front();
					check_field("mean", want.mean, results_if.mean);
					check_field("std_dev", want.std_dev, results_if.std_dev);
					check_field("count", want.count, results_if.count);
					check_field("overflowed", want.overflowed, results_if.overflowed);
					if (results_if.overflowed)
						runs_dropped++;
					runs_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				// two results in every eight go through with no stalling
				if (runs_checked % 8 >= 2 && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 24);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------

	initial begin
		int  base;
		int  len;
		bit  long_done;
		hold_point  = -1;
		long_done   = 1'b0;
		run_sum     = 0;
		run_len     = 0;
		run_dropped = 1'b0;

		// single sample runs at both ends of the range
		push_sample(32767, 1);
		push_sample(-32768, 1);
		// widest spread the field allows
		push_sample(-32768, 0);
		push_sample(32767, 1);
		// mean at its extremes
		push_sample(32767, 0);
		push_sample(32767, 1);
		push_sample(-32768, 0);
		push_sample(-32768, 0);
		push_sample(-32768, 1);
		// small negative sum, mean truncated toward zero
		push_sample(-1, 0);
		push_sample(0, 0);
		push_sample(0, 1);
		push_sample(-5, 0);
		push_sample(-6, 0);
		push_sample(-7, 0);
		push_sample(-7, 1);
		// alternating bit patterns
		push_sample(16'sh5555, 0);
		push_sample(-21846, 0);
		push_sample(16'sh5555, 0);
		push_sample(-21846, 1);
		push_sample(1, 0);
		push_sample(2, 0);
		push_sample(3, 0);
		push_sample(4, 1);

		// random runs, one of them past capacity so samples are dropped
		base = sample_feed.size();
		while (sample_feed.size() - base < RANDOM_ITEMS) begin
			if (!long_done && sample_feed.size() - base >= 150) begin
				len       = MAX_SAMPLES + $urandom_range(1, 6);
				long_done = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(13, 64);
			end else begin
				len = $urandom_range(1, 12);
			end
			add_run(len);
			// one hold-off at a run boundary until every result is back
			if (hold_point < 0 && sample_feed.size() - base >= 60)
				hold_point = sample_feed.size();
		end

		wait (arst_n === 1'b1);
		while (sample_feed.size() != 0 || stats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples in %0d checked runs, %0d of them with dropped samples",
			n_accepted, runs_checked, runs_dropped);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
